FILE: src/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// shared types and constants of the mip-chain box downsampler
// ----------------------------------------------------------------------------
package mmbd_pkg;

   localparam int NUM_CH      = 4;
   localparam int SAMPLE_W    = 16;
   localparam int PAIR_W      = SAMPLE_W + 1;
   localparam int LEVEL_BITS  = 4;
   localparam int POS_OUT_W   = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int CH_CNT_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS   = 2'd2;

   typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pix_type;
   typedef logic [NUM_CH-1:0][PAIR_W-1:0]   pair_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_PAIR,
      ACT_OUT
   } act_type;

   typedef struct packed {
      logic                  valid;
      act_type               act;
      logic [LEVEL_BITS-1:0] level;
      logic [POS_OUT_W-1:0]  row;
      logic [POS_OUT_W-1:0]  col;
      logic                  final_flag;
      pix_type               samples;
   } iss_type;

endpackage

FILE: src/mmbd_pend_mem.sv
// ----------------------------------------------------------------------------
// mmbd_pend_mem
// pending pair-sum memory, registered read, write-to-read forwarding
// ----------------------------------------------------------------------------
module mmbd_pend_mem #(
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  mmbd_pkg::pair_type   wr_data,
   output mmbd_pkg::pair_type   rd_data
);
   import mmbd_pkg::*;

   pair_type mem [2**ADDR_BITS];
   pair_type rd_data_ff;
   pair_type fwd_data_ff;
   logic     fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

endmodule

FILE: src/mmbd_walk.sv
// ----------------------------------------------------------------------------
// mmbd_walk
// level-0 position tracking and per-level issue sequencing
// ----------------------------------------------------------------------------
module mmbd_walk #(
   parameter int MAX_LOG_SIZE = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            frame_start,
   input  mmbd_pkg::pix_type               samples,
   input  logic [mmbd_pkg::LEVEL_BITS-1:0] lw,
   input  logic [mmbd_pkg::LEVEL_BITS-1:0] lh,
   input  logic [mmbd_pkg::LEVEL_BITS-1:0] nlev,
   input  logic [mmbd_pkg::CH_CNT_W-1:0]   nch,
   input  logic                            ex_ready,
   output mmbd_pkg::iss_type               iss,
   output logic                            rd_en,
   output logic [MAX_LOG_SIZE-1:0]         slot
);
   import mmbd_pkg::*;

   localparam int PB = MAX_LOG_SIZE + 1;

   logic [PB-1:0]           row_ff, col_ff;
   logic [PB-1:0]           row_in, col_in, col_pre, row_pre;
   logic [MAX_LOG_SIZE-1:0] r_ff, c_ff;
   logic [LEVEL_BITS-1:0]   level_ff;
   logic                    iss_valid_ff;
   pix_type                 samples_ff, samples_in;
   logic [PB-1:0]           sr_w, sc_w, base, one_w;
   logic [4:0]              base_sh;
   act_type                 act;
   logic                    last_lv, terminal, take, acc;

   assign one_w = {{(PB-1){1'b0}}, 1'b1};

   always_comb begin
      col_pre = frame_start ? '0 : col_ff;
      row_pre = frame_start ? '0 : row_ff;
      col_in  = col_pre;
      row_in  = row_pre;
      if (col_pre >= (one_w << lw)) begin
         col_in = '0;
         row_in = row_pre + one_w;
      end
      if (row_in >= (one_w << lh)) begin
         row_in = '0;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         samples_in[ch] = (ch < int'(nch)) ? samples[ch] : '0;
      end
   end

   always_comb begin
      sr_w    = {1'b0, r_ff} >> (level_ff - 1'b1);
      sc_w    = {1'b0, c_ff} >> (level_ff - 1'b1);
      base_sh = 5'(PB) - 5'(level_ff);
      base    = (one_w << MAX_LOG_SIZE) - (one_w << base_sh);
      slot    = MAX_LOG_SIZE'(base + {1'b0, sc_w[PB-1:1]});
      if (!sc_w[0]) begin
         act = ACT_HOLD;
      end else if (!sr_w[0]) begin
         act = ACT_PAIR;
      end else begin
         act = ACT_OUT;
      end
      last_lv  = (level_ff == nlev);
      terminal = (act != ACT_OUT) || last_lv;
   end

   assign take       = iss_valid_ff && ex_ready;
   assign rd_en      = take;
   assign req_tready = !iss_valid_ff || (take && terminal);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      iss.valid      = iss_valid_ff;
      iss.act        = act;
      iss.level      = level_ff;
      iss.row        = POS_OUT_W'(sr_w >> 1);
      iss.col        = POS_OUT_W'(sc_w >> 1);
      iss.final_flag = (act == ACT_OUT) && !(!last_lv && sc_w[1] && sr_w[1]);
      iss.samples    = samples_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         iss_valid_ff <= 1'b0;
      end else begin
         if (acc) begin
            row_ff       <= row_in;
            col_ff       <= col_in + one_w;
            iss_valid_ff <= (nlev != '0);
            level_ff     <= LEVEL_BITS'(1);
            r_ff         <= MAX_LOG_SIZE'(row_in);
            c_ff         <= MAX_LOG_SIZE'(col_in);
            samples_ff   <= samples_in;
         end else if (take && !terminal) begin
            level_ff <= level_ff + 1'b1;
         end else if (take) begin
            iss_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: src/mipmap_box_downsampler.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsampler
// streaming 2x2 box-filter mip-chain generator
// ----------------------------------------------------------------------------
// pipeline: a request is registered in the level walker, then in the execute
//   stage, then in the response register; further levels follow in order
// throughput: 1 request per cycle when output does not stall; a multi-level
//   request holds the level walker, one pending-sum memory read per level
// reset: position counters cleared, sizes 8/8, 4 channels; memory not cleared
module mipmap_box_downsampler #(
   parameter int MAX_LOG_SIZE = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,  // sample_a, sample_b, sample_c, sample_d
   input  logic                            req_tuser,  // frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [87:0]                     rsp_tdata,  // mip_level, out_row, out_column,
                                                       // avg_a, avg_b, avg_c, avg_d
   output logic                            rsp_tlast,  // final_of_item
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mmbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mmbd_pkg::CSR_DATA_W-1:0] csr_data
);
   import mmbd_pkg::*;

   localparam int HB = $clog2(MAX_LOG_SIZE + 1);

   logic [LEVEL_BITS-1:0] log_width_ff, log_height_ff, lw, lh, nlev;
   logic [CH_CNT_W-1:0]   channels_ff, nch;
   iss_type               iss, ex_ff;
   logic [MAX_LOG_SIZE-1:0] slot, ex_slot_ff;
   logic                  rd_en, ex_ready, done, out_free;
   pair_type              pend_rd, pair_sum;
   pix_type               hold_ff [MAX_LOG_SIZE+1];
   pix_type               v, hold_sel, avg, avg_ff;
   logic [HB-1:0]         hidx;
   logic                  rsp_valid_ff, rsp_last_ff;
   logic [87:0]           rsp_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_width_ff  <= LEVEL_BITS'(8);
         log_height_ff <= LEVEL_BITS'(8);
         channels_ff   <= CH_CNT_W'(4);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOG_WIDTH:  log_width_ff  <= csr_data[LEVEL_BITS-1:0];
            CSR_LOG_HEIGHT: log_height_ff <= csr_data[LEVEL_BITS-1:0];
            CSR_CHANNELS:   channels_ff   <= csr_data[CH_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lw   = (log_width_ff > LEVEL_BITS'(MAX_LOG_SIZE)) ? LEVEL_BITS'(MAX_LOG_SIZE)
                                                        : log_width_ff;
      lh   = (log_height_ff > LEVEL_BITS'(MAX_LOG_SIZE)) ? LEVEL_BITS'(MAX_LOG_SIZE)
                                                         : log_height_ff;
      nlev = (lw < lh) ? lw : lh;
      if (channels_ff == '0) begin
         nch = CH_CNT_W'(1);
      end else if (channels_ff > CH_CNT_W'(NUM_CH)) begin
         nch = CH_CNT_W'(NUM_CH);
      end else begin
         nch = channels_ff;
      end
   end

   mmbd_walk #(.MAX_LOG_SIZE(MAX_LOG_SIZE)) u_walk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .frame_start (req_tuser),
      .samples     (req_tdata),
      .lw          (lw),
      .lh          (lh),
      .nlev        (nlev),
      .nch         (nch),
      .ex_ready    (ex_ready),
      .iss         (iss),
      .rd_en       (rd_en),
      .slot        (slot)
   );

   mmbd_pend_mem #(.ADDR_BITS(MAX_LOG_SIZE)) u_pend (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .wr_en   (done && (ex_ff.act == ACT_PAIR)),
      .wr_addr (ex_slot_ff),
      .wr_data (pair_sum),
      .rd_data (pend_rd)
   );

   // execute stage
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ex_ready = !ex_ff.valid || (ex_ff.act != ACT_OUT) || out_free;
   assign done     = ex_ff.valid && ex_ready;
   assign hidx     = HB'(ex_ff.level);

   always_comb begin
      v        = (ex_ff.level == LEVEL_BITS'(1)) ? ex_ff.samples : avg_ff;
      hold_sel = hold_ff[hidx];
      for (int ch = 0; ch < NUM_CH; ch++) begin
         logic [PAIR_W:0] tot;
         pair_sum[ch] = {1'b0, hold_sel[ch]} + {1'b0, v[ch]};
         tot          = {1'b0, pend_rd[ch]} + {2'b0, hold_sel[ch]} + {2'b0, v[ch]};
         avg[ch]      = tot[PAIR_W:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff.valid <= 1'b0;
      end else if (ex_ready) begin
         ex_ff       <= iss;
         ex_slot_ff  <= slot;
      end
   end

   always_ff @(posedge clock) begin
      if (done && (ex_ff.act == ACT_HOLD)) begin
         hold_ff[hidx] <= v;
      end
      if (done && (ex_ff.act == ACT_OUT)) begin
         avg_ff <= avg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && (ex_ff.act == ACT_OUT)) begin
         rsp_valid_ff <= 1'b1;
         rsp_last_ff  <= ex_ff.final_flag;
         rsp_data_ff  <= {2'b00, avg[3], avg[2], avg[1], avg[0],
                          ex_ff.col, ex_ff.row, ex_ff.level};
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> iss.valid)
      else $error("request stalled with an idle walker");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (done && (ex_ff.act == ACT_OUT)) |=> rsp_valid_ff)
      else $error("averaged pixel not registered");

   a_level_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[LEVEL_BITS-1:0] != '0))
      else $error("response with level zero");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the mip-chain box downsampler: textures of random or
// extreme content are streamed under several size and channel settings, every
// 2x2 average is predicted in the bench and compared field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import mmbd_pkg::*;

   localparam int MAX_LOG   = 10;
   localparam int SLOT_CNT  = (1 << MAX_LOG) - 1;
   localparam int SETTLE    = 20;

   typedef struct {
      logic                  frame_start;
      logic [SAMPLE_W-1:0]   samples [NUM_CH];
   } pixel_req_type;

   typedef struct {
      logic [LEVEL_BITS-1:0] level;
      logic [POS_OUT_W-1:0]  row;
      logic [POS_OUT_W-1:0]  col;
      logic [SAMPLE_W-1:0]   avg [NUM_CH];
      logic                  last;
   } mip_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;  // sample_a, sample_b, sample_c, sample_d
   logic req_tuser = 1'b0;       // frame_start
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;       // mip_level, out_row, out_column, avg_a..avg_d
   logic rsp_tlast;              // final_of_item
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   mipmap_box_downsampler dut (.*);

   pixel_req_type  pixel_queue [$];
   mip_pixel_type  expected_mips [$];
   int          error_count = 0;
   logic        req_taken = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_count = 0;

   // predictor state
   int unsigned pair_sums [SLOT_CNT][NUM_CH];
   int unsigned left_hold [MAX_LOG+1][NUM_CH];
   int unsigned pos_row = 0;
   int unsigned pos_col = 0;
   int unsigned cfg_log_w = 8;
   int unsigned cfg_log_h = 8;
   int unsigned cfg_chans = 4;

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("[mipmap_box_downsampler] ERROR");
      $finish;
   end

   function automatic void predict_pixel(input pixel_req_type px);
      int unsigned lw, lh, nch, nlev, sr, sc, slot;
      int unsigned v [NUM_CH];
      mip_pixel_type res;
      mip_pixel_type found [$];
      lw = cfg_log_w > MAX_LOG ? MAX_LOG : cfg_log_w;
      lh = cfg_log_h > MAX_LOG ? MAX_LOG : cfg_log_h;
      nch = cfg_chans < 1 ? 1 : (cfg_chans > NUM_CH ? NUM_CH : cfg_chans);
      nlev = lw < lh ? lw : lh;
      if (px.frame_start) begin
         pos_row = 0;
         pos_col = 0;
      end
      if (pos_col >= (1 << lw)) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row >= (1 << lh)) pos_row = 0;
      for (int ch = 0; ch < NUM_CH; ch++) v[ch] = ch < nch ? 32'(px.samples[ch]) : 0;
      for (int lv = 1; lv <= nlev; lv++) begin
         sr = pos_row >> (lv - 1);
         sc = pos_col >> (lv - 1);
         slot = (1 << MAX_LOG) - (1 << (MAX_LOG - lv + 1)) + (sc >> 1);
         if (slot >= SLOT_CNT) break;
         if (!sc[0]) begin
            for (int ch = 0; ch < NUM_CH; ch++) left_hold[lv][ch] = v[ch];
            break;
         end
         if (!sr[0]) begin
            for (int ch = 0; ch < NUM_CH; ch++)
               pair_sums[slot][ch] = left_hold[lv][ch] + v[ch];
            break;
         end
         for (int ch = 0; ch < NUM_CH; ch++) begin
            v[ch] = (pair_sums[slot][ch] + left_hold[lv][ch] + v[ch]) >> 2;
            res.avg[ch] = v[ch][SAMPLE_W-1:0];
         end
         res.level = lv[LEVEL_BITS-1:0];
         res.row = sr[POS_OUT_W:1];
         res.col = sc[POS_OUT_W:1];
         res.last = 1'b0;
         found = {found, res};
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) expected_mips = {expected_mips, found[i]};
      pos_col++;
   endfunction

   // monitor: prediction on accepted requests, checking of results
   always @(posedge clock) begin
      pixel_req_type px;
      mip_pixel_type exp_px;
      logic [87:0] d;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOG_WIDTH:  cfg_log_w = 32'(csr_data);
            CSR_LOG_HEIGHT: cfg_log_h = 32'(csr_data);
            CSR_CHANNELS:   cfg_chans = 32'(csr_data[CH_CNT_W-1:0]);
            default: ;
         endcase
      end
      if (!reset && req_tvalid && req_tready) begin
         px.frame_start = req_tuser;
         for (int ch = 0; ch < NUM_CH; ch++) px.samples[ch] = req_tdata[16*ch +: 16];
         predict_pixel(px);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         d = rsp_tdata;
         if (expected_mips.size() == 0) begin
            $error("unexpected result level %0d row %0d col %0d", d[3:0], d[12:4], d[21:13]);
            error_count++;
         end else begin
            exp_px = expected_mips.pop_front();
            if (d[3:0] !== exp_px.level) begin
               $error("mip_level expected %0d actual %0d", exp_px.level, d[3:0]);
               error_count++;
            end
            if (d[12:4] !== exp_px.row) begin
               $error("out_row expected %0d actual %0d", exp_px.row, d[12:4]);
               error_count++;
            end
            if (d[21:13] !== exp_px.col) begin
               $error("out_column expected %0d actual %0d", exp_px.col, d[21:13]);
               error_count++;
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (d[22+16*ch +: 16] !== exp_px.avg[ch]) begin
                  $error("avg_%c expected %h actual %h", 8'(97 + ch),
                         exp_px.avg[ch], d[22+16*ch +: 16]);
                  error_count++;
               end
            end
            if (rsp_tlast !== exp_px.last) begin
               $error("final_of_item expected %0d actual %0d", exp_px.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // driver: bursts of requests with random gaps, receiver stall pattern
   always @(negedge clock) begin
      pixel_req_type px;
      logic next_valid;
      logic [63:0] tdata_next;
      next_valid = req_tvalid && !req_taken;
      if (!reset && !next_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pixel_queue.size() > 0) begin
            px = pixel_queue.pop_front();
            req_tuser <= px.frame_start;
            for (int ch = 0; ch < NUM_CH; ch++) tdata_next[16*ch +: 16] = px.samples[ch];
            req_tdata <= tdata_next;
            next_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            end
         end
      end
      req_tvalid <= next_valid;
      if (stall_count == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_count = $urandom_range(10, 80);
      end
      stall_count--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_count % 4) != 0;
         default: rsp_tready <= $urandom_range(0, 7) == 0;
      endcase
   end

   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_tvalid || expected_mips.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned lw, input int unsigned lh,
                            input int unsigned ch);
      wait_idle();
      write_reg(CSR_LOG_WIDTH, lw);
      write_reg(CSR_LOG_HEIGHT, lh);
      write_reg(CSR_CHANNELS, ch);
   endtask

   // sample style: 0 random, 1 all zero, 2 all max, 3 mixed extremes
   task automatic queue_pixels(input int count, input int style, input bit noise_starts);
      pixel_req_type px;
      for (int i = 0; i < count; i++) begin
         px.frame_start = (i == 0) || (noise_starts && $urandom_range(0, 40) == 0);
         for (int ch = 0; ch < NUM_CH; ch++) begin
            case (style)
               1: px.samples[ch] = '0;
               2: px.samples[ch] = '1;
               3: px.samples[ch] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
               default: px.samples[ch] = 16'($urandom());
            endcase
         end
         pixel_queue = {pixel_queue, px};
      end
   endtask

   initial begin
      int lw, lh, eff, sent, cnt;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short directed set
      configure(1, 1, 4);
      queue_pixels(4, 2, 0);
      queue_pixels(4, 1, 0);
      queue_pixels(4, 3, 0);
      configure(0, 0, 0);
      queue_pixels(2, 0, 0);
      configure(2, 2, 7);
      queue_pixels(16, 0, 0);
      configure(1, 2, 1);
      queue_pixels(8, 0, 0);

      // widest and tallest shapes, with clamped size values
      configure(10, 1, 4);
      queue_pixels(64, 0, 0);
      configure(1, 15, 3);
      queue_pixels(64, 0, 0);
      configure(12, 0, 2);
      queue_pixels(40, 0, 0);

      // random phases, mostly whole textures with random content
      sent = 0;
      while (sent < 250) begin
         lw = $urandom_range(0, 4);
         lh = $urandom_range(0, 4);
         if ($urandom_range(0, 9) == 0) lw = $urandom_range(11, 15);
         eff = lw > MAX_LOG ? 5 : lw;
         if (eff > 5) eff = 5;
         configure(lw > MAX_LOG ? lw : lw, lh, $urandom_range(0, 7));
         for (int t = 0; t < $urandom_range(1, 3); t++) begin
            cnt = (1 << eff) * (1 << lh);
            if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, cnt);
            queue_pixels(cnt, $urandom_range(0, 5) > 3 ? $urandom_range(1, 3) : 0,
                         $urandom_range(0, 3) == 0);
            sent += cnt;
         end
      end

      wait_idle();
      if (error_count == 0 && expected_mips.size() == 0) begin
         $display("[mipmap_box_downsampler] OK");
      end else begin
         $display("[mipmap_box_downsampler] ERROR");
      end
      $finish;
   end

endmodule
